// ===== rtl/core/ghe_pkg.sv =====
`default_nettype none

package ghe_pkg;

    localparam int VB   = 32;
    localparam int FRAC = 24;

    typedef logic signed [VB-1:0] val_t;

    localparam val_t VMAX = {1'b0, {(VB-1){1'b1}}};
    localparam val_t VMIN = {1'b1, {(VB-1){1'b0}}};

    localparam logic [24:0] ONE_Q = 25'h100_0000;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_RUN   = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [1:0] STATUS_WRITE = 2'd0;
    localparam logic [1:0] STATUS_RUN   = 2'd1;
    localparam logic [1:0] STATUS_READ  = 2'd2;

    localparam logic [1:0] NB_ORTHO = 2'd1;
    localparam logic [1:0] NB_DIAG  = 2'd2;

    localparam logic [2:0] REG_RAIN   = 3'd0;
    localparam logic [2:0] REG_SOL    = 3'd1;
    localparam logic [2:0] REG_EVAP   = 3'd2;
    localparam logic [2:0] REG_CAP    = 3'd3;
    localparam logic [2:0] REG_PASSES = 3'd4;
    localparam logic [2:0] REG_NBH    = 3'd5;
    localparam logic [2:0] REG_WIDTH  = 3'd6;
    localparam logic [2:0] REG_HEIGHT = 3'd7;

    localparam logic signed [1:0] OFS_M1 = 2'sb11;
    localparam logic signed [1:0] OFS_Z0 = 2'sb00;
    localparam logic signed [1:0] OFS_P1 = 2'sb01;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_FINISH,
        ST_MUL,
        ST_DIV,
        ST_R_RD,
        ST_R_RAIN,
        ST_R_UPD,
        ST_T_RD,
        ST_T_CTR,
        ST_T_NB,
        ST_T_NBCHK,
        ST_T_AVG,
        ST_T_MIN,
        ST_T_DW,
        ST_T_DM,
        ST_T_DMQ,
        ST_T_CRD,
        ST_T_CWR,
        ST_T_NRD,
        ST_T_NWR,
        ST_E_RD,
        ST_E_ADD,
        ST_E_KEEP,
        ST_E_CAP
    } state_t;

    typedef struct packed {
        logic signed [1:0] dx;
        logic signed [1:0] dy;
    } offset_t;

    function automatic offset_t nb_offset(logic [1:0] mode, logic [2:0] k);
        offset_t o;
        case (mode)
            NB_ORTHO:
            begin
                case (k[1:0])
                    2'd0:    o = '{OFS_Z0, OFS_M1};
                    2'd1:    o = '{OFS_M1, OFS_Z0};
                    2'd2:    o = '{OFS_P1, OFS_Z0};
                    default: o = '{OFS_Z0, OFS_P1};
                endcase
            end
            NB_DIAG:
            begin
                case (k[1:0])
                    2'd0:    o = '{OFS_M1, OFS_M1};
                    2'd1:    o = '{OFS_P1, OFS_M1};
                    2'd2:    o = '{OFS_M1, OFS_P1};
                    default: o = '{OFS_P1, OFS_P1};
                endcase
            end
            default:
            begin
                case (k)
                    3'd0:    o = '{OFS_M1, OFS_M1};
                    3'd1:    o = '{OFS_Z0, OFS_M1};
                    3'd2:    o = '{OFS_P1, OFS_M1};
                    3'd3:    o = '{OFS_M1, OFS_Z0};
                    3'd4:    o = '{OFS_P1, OFS_Z0};
                    3'd5:    o = '{OFS_M1, OFS_P1};
                    3'd6:    o = '{OFS_Z0, OFS_P1};
                    default: o = '{OFS_P1, OFS_P1};
                endcase
            end
        endcase
        return o;
    endfunction

    function automatic logic [3:0] nb_count(logic [1:0] mode);
        logic [3:0] c;
        case (mode)
            NB_ORTHO: c = 4'd4;
            NB_DIAG:  c = 4'd4;
            default:  c = 4'd8;
        endcase
        return c;
    endfunction

    function automatic val_t sat36(logic signed [35:0] v);
        val_t r;
        if (v > 36'(VMAX)) r = VMAX;
        else if (v < 36'(VMIN)) r = VMIN;
        else r = v[VB-1:0];
        return r;
    endfunction

    function automatic val_t sat_add(val_t a, val_t b);
        logic signed [35:0] s;
        s = 36'(a) + 36'(b);
        return sat36(s);
    endfunction

    function automatic val_t sat_sub(val_t a, val_t b);
        logic signed [35:0] s;
        s = 36'(a) - 36'(b);
        return sat36(s);
    endfunction

    function automatic val_t sat_mag(logic [63:0] q, logic neg);
        val_t r;
        if (neg) begin
            if (q > 64'h8000_0000) r = VMIN;
            else r = val_t'(32'd0 - q[31:0]);
        end else begin
            if (q > 64'h7FFF_FFFF) r = VMAX;
            else r = val_t'(q[31:0]);
        end
        return r;
    endfunction

    function automatic logic [VB-1:0] mag_of(val_t v);
        logic [VB-1:0] u;
        u = v;
        return u[VB-1] ? (~u + 1'b1) : u;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/grid_hydraulic_erosion.sv =====
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid / in_stall | operation, cell_x, cell_y, height_in
// out     | output    | out_valid/out_stall | status, height_out, water_out, sediment_out
// cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// A write passes the execute and finish states; a read adds a wait for the cell memory read.
// A run takes each pass through rain, flow and evaporation over every cell; the flow
// step reads each in-range neighbour and, for the lower ones, calls on the
// one-bit-per-cycle divider that serves the average, water and sediment shares.
// After reset a clearing pass over all DEPTH cells, MAX_SIDE rounded up to a power of two,
// squared (65536 by default), zeroes water, sediment and deltas and takes no item.
// A finished result waits in the output register while the next item is taken.
`default_nettype none

module grid_hydraulic_erosion #(
    parameter int MAX_SIDE = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         operation,
    input  logic [7:0]         cell_x,
    input  logic [7:0]         cell_y,
    input  logic signed [31:0] height_in,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic signed [31:0] height_out,
    output logic signed [31:0] water_out,
    output logic signed [31:0] sediment_out,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam int XB    = $clog2(MAX_SIDE);
    localparam int SW    = XB + 1;
    localparam int AW    = 2 * XB;
    localparam int DEPTH = 1 << AW;

    logic [95:0] cell_mem [DEPTH];
    logic [63:0] delta_mem [DEPTH];
    logic [95:0] cm_q_reg;
    logic [63:0] dm_q_reg;

    logic [AW-1:0]     cm_addr;
    logic              cm_rd;
    logic              cm_we_h;
    logic              cm_we_ws;
    ghe_pkg::val_t     cm_wh;
    ghe_pkg::val_t     cm_ww;
    ghe_pkg::val_t     cm_ws;
    logic [AW-1:0]     dm_addr;
    logic              dm_rd;
    logic              dm_we;
    ghe_pkg::val_t     dm_ww;
    ghe_pkg::val_t     dm_ws;

    logic [31:0] rain_reg;
    logic [31:0] sol_reg;
    logic [24:0] evap_reg;
    logic [31:0] cap_reg;
    logic [7:0]  passes_reg;
    logic [1:0]  nbh_reg;
    logic [8:0]  width_reg;
    logic [8:0]  height_reg;

    ghe_pkg::state_t state_reg, state_next;
    ghe_pkg::state_t mul_ret_reg, mul_ret_next;
    ghe_pkg::state_t div_ret_reg, div_ret_next;
    logic [AW-1:0]   clr_reg, clr_next;
    logic            out_valid_reg, out_valid_next;
    logic [5:0]      cnt_reg, cnt_next;

    logic [1:0]          op_reg, op_next;
    logic [XB-1:0]       x_reg, x_next;
    logic [XB-1:0]       y_reg, y_next;
    ghe_pkg::val_t       hin_reg, hin_next;
    logic [7:0]          pass_reg, pass_next;
    ghe_pkg::val_t       w_reg, w_next;
    ghe_pkg::val_t       s_reg, s_next;
    ghe_pkg::val_t       h_reg, h_next;
    ghe_pkg::val_t       a_reg, a_next;
    ghe_pkg::val_t       minv_reg, minv_next;
    ghe_pkg::val_t       dw_reg, dw_next;
    ghe_pkg::val_t       dm_reg, dm_next;
    ghe_pkg::val_t       dtot_reg, dtot_next;
    logic signed [34:0]  asum_reg, asum_next;
    logic [3:0]          n_reg, n_next;
    logic [3:0]          k_reg, k_next;
    logic [2:0]          j_reg, j_next;
    logic [AW-1:0]       nb_cur_reg, nb_cur_next;
    logic [AW-1:0]       nb_addr_reg [8];
    logic [AW-1:0]       nb_addr_next [8];
    ghe_pkg::val_t       d_reg [8];
    ghe_pkg::val_t       d_next [8];
    logic [31:0]         mul_a_reg, mul_a_next;
    logic [31:0]         mul_b_reg, mul_b_next;
    logic [63:0]         prod_reg, prod_next;
    logic                neg_reg, neg_next;
    logic [31:0]         div_c_reg, div_c_next;
    logic [31:0]         rem_reg, rem_next;
    logic [1:0]          out_status_reg, out_status_next;
    ghe_pkg::val_t       out_h_reg, out_h_next;
    ghe_pkg::val_t       out_w_reg, out_w_next;
    ghe_pkg::val_t       out_s_reg, out_s_next;

    logic [SW-1:0] gw;
    logic [SW-1:0] gh;
    logic [XB-1:0] in_x;
    logic [XB-1:0] in_y;
    logic [AW-1:0] cell_addr;
    logic          x_last;
    logic          y_last;
    logic [24:0]   keep;

    ghe_pkg::val_t cq_h, cq_w, cq_s, dq_w, dq_s;

    assign cq_h = cm_q_reg[31:0];
    assign cq_w = cm_q_reg[63:32];
    assign cq_s = cm_q_reg[95:64];
    assign dq_w = dm_q_reg[31:0];
    assign dq_s = dm_q_reg[63:32];

    assign cell_addr = {y_reg, x_reg};
    assign x_last    = ({1'b0, x_reg} == gw - 1'b1);
    assign y_last    = ({1'b0, y_reg} == gh - 1'b1);
    assign keep      = ghe_pkg::ONE_Q - ((evap_reg > ghe_pkg::ONE_Q) ? ghe_pkg::ONE_Q : evap_reg);

    always_comb
    begin
        logic [15:0] w16;
        logic [15:0] h16;
        logic [15:0] cx16;
        logic [15:0] cy16;
        w16 = {7'd0, width_reg};
        h16 = {7'd0, height_reg};
        if (w16 < 16'd2) w16 = 16'd2;
        else if (w16 > 16'(MAX_SIDE)) w16 = 16'(MAX_SIDE);
        if (h16 < 16'd2) h16 = 16'd2;
        else if (h16 > 16'(MAX_SIDE)) h16 = 16'(MAX_SIDE);
        cx16 = {8'd0, cell_x};
        cy16 = {8'd0, cell_y};
        if (cx16 > w16 - 16'd1) cx16 = w16 - 16'd1;
        if (cy16 > h16 - 16'd1) cy16 = h16 - 16'd1;
        gw   = w16[SW-1:0];
        gh   = h16[SW-1:0];
        in_x = cx16[XB-1:0];
        in_y = cy16[XB-1:0];
    end

    assign cfg_ready    = 1'b1;
    assign in_stall     = (state_reg != ghe_pkg::ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign height_out   = out_h_reg;
    assign water_out    = out_w_reg;
    assign sediment_out = out_s_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rain_reg   <= 32'd25166;
            sol_reg    <= 32'd419430;
            evap_reg   <= 25'd2516582;
            cap_reg    <= 32'd167772160;
            passes_reg <= 8'd50;
            nbh_reg    <= 2'd0;
            width_reg  <= 9'd256;
            height_reg <= 9'd256;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                ghe_pkg::REG_RAIN:   rain_reg   <= cfg_data;
                ghe_pkg::REG_SOL:    sol_reg    <= cfg_data;
                ghe_pkg::REG_EVAP:   evap_reg   <= cfg_data[24:0];
                ghe_pkg::REG_CAP:    cap_reg    <= cfg_data;
                ghe_pkg::REG_PASSES: passes_reg <= cfg_data[7:0];
                ghe_pkg::REG_NBH:    nbh_reg    <= cfg_data[1:0];
                ghe_pkg::REG_WIDTH:  width_reg  <= cfg_data[8:0];
                ghe_pkg::REG_HEIGHT: height_reg <= cfg_data[8:0];
                default:             rain_reg   <= rain_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cm_we_h) begin
            cell_mem[cm_addr][31:0] <= cm_wh;
        end
        if (cm_we_ws) begin
            cell_mem[cm_addr][63:32] <= cm_ww;
            cell_mem[cm_addr][95:64] <= cm_ws;
        end
        if (cm_rd) begin
            cm_q_reg <= cell_mem[cm_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (dm_we) begin
            delta_mem[dm_addr] <= {dm_ws, dm_ww};
        end
        if (dm_rd) begin
            dm_q_reg <= delta_mem[dm_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ghe_pkg::ST_CLEAR;
            mul_ret_reg   <= ghe_pkg::ST_IDLE;
            div_ret_reg   <= ghe_pkg::ST_IDLE;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= 6'd0;
            pass_reg      <= 8'd0;
            n_reg         <= 4'd0;
            k_reg         <= 4'd0;
            j_reg         <= 3'd0;
        end else begin
            state_reg     <= state_next;
            mul_ret_reg   <= mul_ret_next;
            div_ret_reg   <= div_ret_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            pass_reg      <= pass_next;
            n_reg         <= n_next;
            k_reg         <= k_next;
            j_reg         <= j_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        x_reg          <= x_next;
        y_reg          <= y_next;
        hin_reg        <= hin_next;
        w_reg          <= w_next;
        s_reg          <= s_next;
        h_reg          <= h_next;
        a_reg          <= a_next;
        minv_reg       <= minv_next;
        dw_reg         <= dw_next;
        dm_reg         <= dm_next;
        dtot_reg       <= dtot_next;
        asum_reg       <= asum_next;
        nb_cur_reg     <= nb_cur_next;
        nb_addr_reg    <= nb_addr_next;
        d_reg          <= d_next;
        mul_a_reg      <= mul_a_next;
        mul_b_reg      <= mul_b_next;
        prod_reg       <= prod_next;
        neg_reg        <= neg_next;
        div_c_reg      <= div_c_next;
        rem_reg        <= rem_next;
        out_status_reg <= out_status_next;
        out_h_reg      <= out_h_next;
        out_w_reg      <= out_w_next;
        out_s_reg      <= out_s_next;
    end

    always_comb
    begin
        ghe_pkg::val_t     t_w;
        ghe_pkg::val_t     t_s;
        ghe_pkg::val_t     t_e;
        ghe_pkg::val_t     t_ai;
        ghe_pkg::val_t     t_ex;
        ghe_pkg::offset_t  t_off;
        logic signed [XB+1:0] t_nx;
        logic signed [XB+1:0] t_ny;
        logic [32:0]       t_r2;
        logic [34:0]       t_au;
        logic              t_last;

        state_next      = state_reg;
        mul_ret_next    = mul_ret_reg;
        div_ret_next    = div_ret_reg;
        clr_next        = clr_reg;
        out_valid_next  = out_valid_reg;
        cnt_next        = cnt_reg;
        op_next         = op_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        hin_next        = hin_reg;
        pass_next       = pass_reg;
        w_next          = w_reg;
        s_next          = s_reg;
        h_next          = h_reg;
        a_next          = a_reg;
        minv_next       = minv_reg;
        dw_next         = dw_reg;
        dm_next         = dm_reg;
        dtot_next       = dtot_reg;
        asum_next       = asum_reg;
        n_next          = n_reg;
        k_next          = k_reg;
        j_next          = j_reg;
        nb_cur_next     = nb_cur_reg;
        nb_addr_next    = nb_addr_reg;
        d_next          = d_reg;
        mul_a_next      = mul_a_reg;
        mul_b_next      = mul_b_reg;
        prod_next       = prod_reg;
        neg_next        = neg_reg;
        div_c_next      = div_c_reg;
        rem_next        = rem_reg;
        out_status_next = out_status_reg;
        out_h_next      = out_h_reg;
        out_w_next      = out_w_reg;
        out_s_next      = out_s_reg;

        cm_addr  = cell_addr;
        cm_rd    = 1'b0;
        cm_we_h  = 1'b0;
        cm_we_ws = 1'b0;
        cm_wh    = h_reg;
        cm_ww    = w_reg;
        cm_ws    = s_reg;
        dm_addr  = cell_addr;
        dm_rd    = 1'b0;
        dm_we    = 1'b0;
        dm_ww    = '0;
        dm_ws    = '0;

        t_w    = '0;
        t_s    = '0;
        t_e    = '0;
        t_ai   = '0;
        t_ex   = '0;
        t_off  = ghe_pkg::nb_offset(nbh_reg, k_reg[2:0]);
        t_nx   = signed'({2'b00, x_reg}) + (XB+2)'(t_off.dx);
        t_ny   = signed'({2'b00, y_reg}) + (XB+2)'(t_off.dy);
        t_r2   = {rem_reg, prod_reg[63]};
        t_au   = asum_reg[34] ? (35'd0 - asum_reg) : asum_reg;
        t_last = x_last && y_last;

        if (out_valid_reg && !out_stall) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ghe_pkg::ST_CLEAR:
            begin
                cm_addr  = clr_reg;
                cm_we_ws = 1'b1;
                cm_ww    = '0;
                cm_ws    = '0;
                dm_addr  = clr_reg;
                dm_we    = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == {AW{1'b1}}) begin
                    state_next = ghe_pkg::ST_IDLE;
                end
            end
            ghe_pkg::ST_IDLE:
            begin
                if (in_valid) begin
                    op_next    = operation;
                    x_next     = in_x;
                    y_next     = in_y;
                    hin_next   = height_in;
                    state_next = ghe_pkg::ST_EXEC;
                end
            end
            ghe_pkg::ST_EXEC:
            begin
                case (op_reg)
                    ghe_pkg::OP_WRITE:
                    begin
                        cm_we_h    = 1'b1;
                        cm_wh      = hin_reg;
                        state_next = ghe_pkg::ST_FINISH;
                    end
                    ghe_pkg::OP_RUN:
                    begin
                        x_next    = '0;
                        y_next    = '0;
                        pass_next = 8'd0;
                        if (passes_reg == 8'd0) state_next = ghe_pkg::ST_FINISH;
                        else state_next = ghe_pkg::ST_R_RD;
                    end
                    default:
                    begin
                        cm_rd      = 1'b1;
                        state_next = ghe_pkg::ST_READ;
                    end
                endcase
            end
            ghe_pkg::ST_READ:
            begin
                h_next     = cq_h;
                w_next     = cq_w;
                s_next     = cq_s;
                state_next = ghe_pkg::ST_FINISH;
            end
            ghe_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall) begin
                    out_valid_next = 1'b1;
                    out_h_next     = '0;
                    out_w_next     = '0;
                    out_s_next     = '0;
                    case (op_reg)
                        ghe_pkg::OP_WRITE: out_status_next = ghe_pkg::STATUS_WRITE;
                        ghe_pkg::OP_RUN:   out_status_next = ghe_pkg::STATUS_RUN;
                        default:
                        begin
                            out_status_next = ghe_pkg::STATUS_READ;
                            out_h_next      = h_reg;
                            out_w_next      = w_reg;
                            out_s_next      = s_reg;
                        end
                    endcase
                    state_next = ghe_pkg::ST_IDLE;
                end
            end
            ghe_pkg::ST_MUL:
            begin
                prod_next  = mul_a_reg * mul_b_reg;
                state_next = mul_ret_reg;
            end
            ghe_pkg::ST_DIV:
            begin
                if (t_r2 >= {1'b0, div_c_reg}) begin
                    t_r2      = t_r2 - {1'b0, div_c_reg};
                    prod_next = {prod_reg[62:0], 1'b1};
                end else begin
                    prod_next = {prod_reg[62:0], 1'b0};
                end
                rem_next = t_r2[31:0];
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 6'd63) begin
                    state_next = div_ret_reg;
                end
            end
            ghe_pkg::ST_R_RD:
            begin
                cm_rd      = 1'b1;
                state_next = ghe_pkg::ST_R_RAIN;
            end
            ghe_pkg::ST_R_RAIN:
            begin
                t_w          = ghe_pkg::sat36(36'(cq_w) + 36'(rain_reg));
                w_next       = t_w;
                h_next       = cq_h;
                s_next       = cq_s;
                mul_a_next   = sol_reg;
                mul_b_next   = ghe_pkg::mag_of(t_w);
                neg_next     = t_w[31];
                mul_ret_next = ghe_pkg::ST_R_UPD;
                state_next   = ghe_pkg::ST_MUL;
            end
            ghe_pkg::ST_R_UPD:
            begin
                t_e      = ghe_pkg::sat_mag(64'(prod_reg[63:ghe_pkg::FRAC]), neg_reg);
                cm_we_h  = 1'b1;
                cm_we_ws = 1'b1;
                cm_wh    = ghe_pkg::sat_sub(h_reg, t_e);
                cm_ww    = w_reg;
                cm_ws    = ghe_pkg::sat_add(s_reg, t_e);
                if (t_last) begin
                    x_next     = '0;
                    y_next     = '0;
                    state_next = ghe_pkg::ST_T_RD;
                end else begin
                    if (y_last) begin
                        y_next = '0;
                        x_next = x_reg + 1'b1;
                    end else begin
                        y_next = y_reg + 1'b1;
                    end
                    state_next = ghe_pkg::ST_R_RD;
                end
            end
            ghe_pkg::ST_T_RD:
            begin
                cm_rd      = 1'b1;
                state_next = ghe_pkg::ST_T_CTR;
            end
            ghe_pkg::ST_T_CTR:
            begin
                w_next     = cq_w;
                s_next     = cq_s;
                a_next     = ghe_pkg::sat_add(cq_h, cq_w);
                k_next     = 4'd0;
                n_next     = 4'd0;
                dtot_next  = '0;
                asum_next  = '0;
                state_next = ghe_pkg::ST_T_NB;
            end
            ghe_pkg::ST_T_NB:
            begin
                if (k_reg == ghe_pkg::nb_count(nbh_reg)) begin
                    state_next = ghe_pkg::ST_T_AVG;
                end else if (!t_nx[XB+1] && (t_nx[XB:0] < gw)
                             && !t_ny[XB+1] && (t_ny[XB:0] < gh)) begin
                    cm_addr     = {t_ny[XB-1:0], t_nx[XB-1:0]};
                    cm_rd       = 1'b1;
                    nb_cur_next = {t_ny[XB-1:0], t_nx[XB-1:0]};
                    state_next  = ghe_pkg::ST_T_NBCHK;
                end else begin
                    k_next = k_reg + 1'b1;
                end
            end
            ghe_pkg::ST_T_NBCHK:
            begin
                t_ai = ghe_pkg::sat_add(cq_w, cq_h);
                if (t_ai < a_reg) begin
                    t_e                      = ghe_pkg::sat_sub(a_reg, t_ai);
                    nb_addr_next[n_reg[2:0]] = nb_cur_reg;
                    d_next[n_reg[2:0]]       = t_e;
                    dtot_next                = ghe_pkg::sat_add(dtot_reg, t_e);
                    asum_next                = asum_reg + 35'(t_ai);
                    n_next                   = n_reg + 1'b1;
                end
                k_next     = k_reg + 1'b1;
                state_next = ghe_pkg::ST_T_NB;
            end
            ghe_pkg::ST_T_AVG:
            begin
                if (n_reg == 4'd0) begin
                    if (t_last) begin
                        x_next     = '0;
                        y_next     = '0;
                        state_next = ghe_pkg::ST_E_RD;
                    end else begin
                        if (y_last) begin
                            y_next = '0;
                            x_next = x_reg + 1'b1;
                        end else begin
                            y_next = y_reg + 1'b1;
                        end
                        state_next = ghe_pkg::ST_T_RD;
                    end
                end else begin
                    prod_next    = 64'(t_au);
                    div_c_next   = 32'(n_reg);
                    neg_next     = asum_reg[34];
                    rem_next     = '0;
                    cnt_next     = 6'd0;
                    div_ret_next = ghe_pkg::ST_T_MIN;
                    state_next   = ghe_pkg::ST_DIV;
                end
            end
            ghe_pkg::ST_T_MIN:
            begin
                t_e = ghe_pkg::sat_sub(a_reg, ghe_pkg::sat_mag(prod_reg, neg_reg));
                if (w_reg < t_e) t_e = w_reg;
                minv_next  = t_e;
                j_next     = 3'd0;
                state_next = ghe_pkg::ST_T_DW;
            end
            ghe_pkg::ST_T_DW:
            begin
                mul_a_next   = ghe_pkg::mag_of(minv_reg);
                mul_b_next   = ghe_pkg::mag_of(d_reg[j_reg]);
                neg_next     = minv_reg[31] ^ d_reg[j_reg][31] ^ dtot_reg[31];
                div_c_next   = ghe_pkg::mag_of(dtot_reg);
                rem_next     = '0;
                cnt_next     = 6'd0;
                mul_ret_next = ghe_pkg::ST_DIV;
                div_ret_next = ghe_pkg::ST_T_DM;
                state_next   = ghe_pkg::ST_MUL;
            end
            ghe_pkg::ST_T_DM:
            begin
                t_e     = ghe_pkg::sat_mag(prod_reg, neg_reg);
                dw_next = t_e;
                if (w_reg == '0) begin
                    dm_next    = '0;
                    state_next = ghe_pkg::ST_T_CRD;
                end else begin
                    mul_a_next   = ghe_pkg::mag_of(s_reg);
                    mul_b_next   = ghe_pkg::mag_of(t_e);
                    neg_next     = s_reg[31] ^ t_e[31] ^ w_reg[31];
                    div_c_next   = ghe_pkg::mag_of(w_reg);
                    rem_next     = '0;
                    cnt_next     = 6'd0;
                    mul_ret_next = ghe_pkg::ST_DIV;
                    div_ret_next = ghe_pkg::ST_T_DMQ;
                    state_next   = ghe_pkg::ST_MUL;
                end
            end
            ghe_pkg::ST_T_DMQ:
            begin
                dm_next    = ghe_pkg::sat_mag(prod_reg, neg_reg);
                state_next = ghe_pkg::ST_T_CRD;
            end
            ghe_pkg::ST_T_CRD:
            begin
                dm_rd      = 1'b1;
                state_next = ghe_pkg::ST_T_CWR;
            end
            ghe_pkg::ST_T_CWR:
            begin
                dm_we      = 1'b1;
                dm_ww      = ghe_pkg::sat_sub(dq_w, dw_reg);
                dm_ws      = ghe_pkg::sat_sub(dq_s, dm_reg);
                state_next = ghe_pkg::ST_T_NRD;
            end
            ghe_pkg::ST_T_NRD:
            begin
                dm_addr    = nb_addr_reg[j_reg];
                dm_rd      = 1'b1;
                state_next = ghe_pkg::ST_T_NWR;
            end
            ghe_pkg::ST_T_NWR:
            begin
                dm_addr = nb_addr_reg[j_reg];
                dm_we   = 1'b1;
                dm_ww   = ghe_pkg::sat_add(dq_w, dw_reg);
                dm_ws   = ghe_pkg::sat_add(dq_s, dm_reg);
                if ({1'b0, j_reg} == n_reg - 1'b1) begin
                    if (t_last) begin
                        x_next     = '0;
                        y_next     = '0;
                        state_next = ghe_pkg::ST_E_RD;
                    end else begin
                        if (y_last) begin
                            y_next = '0;
                            x_next = x_reg + 1'b1;
                        end else begin
                            y_next = y_reg + 1'b1;
                        end
                        state_next = ghe_pkg::ST_T_RD;
                    end
                end else begin
                    j_next     = j_reg + 1'b1;
                    state_next = ghe_pkg::ST_T_DW;
                end
            end
            ghe_pkg::ST_E_RD:
            begin
                cm_rd      = 1'b1;
                dm_rd      = 1'b1;
                state_next = ghe_pkg::ST_E_ADD;
            end
            ghe_pkg::ST_E_ADD:
            begin
                t_w          = ghe_pkg::sat_add(cq_w, dq_w);
                s_next       = ghe_pkg::sat_add(cq_s, dq_s);
                h_next       = cq_h;
                mul_a_next   = ghe_pkg::mag_of(t_w);
                mul_b_next   = 32'(keep);
                neg_next     = t_w[31];
                mul_ret_next = ghe_pkg::ST_E_KEEP;
                state_next   = ghe_pkg::ST_MUL;
            end
            ghe_pkg::ST_E_KEEP:
            begin
                t_w          = ghe_pkg::sat_mag(64'(prod_reg[63:ghe_pkg::FRAC]), neg_reg);
                w_next       = t_w;
                mul_a_next   = cap_reg;
                mul_b_next   = ghe_pkg::mag_of(t_w);
                neg_next     = t_w[31];
                mul_ret_next = ghe_pkg::ST_E_CAP;
                state_next   = ghe_pkg::ST_MUL;
            end
            ghe_pkg::ST_E_CAP:
            begin
                t_e  = ghe_pkg::sat_mag(64'(prod_reg[63:ghe_pkg::FRAC]), neg_reg);
                t_ex = ghe_pkg::sat_sub(s_reg, t_e);
                if (t_ex[31]) t_ex = '0;
                t_s      = ghe_pkg::sat_sub(s_reg, t_ex);
                cm_we_h  = 1'b1;
                cm_we_ws = 1'b1;
                cm_wh    = ghe_pkg::sat_add(h_reg, t_ex);
                cm_ww    = w_reg;
                cm_ws    = t_s;
                dm_we    = 1'b1;
                if (t_last) begin
                    x_next = '0;
                    y_next = '0;
                    if (pass_reg == passes_reg - 1'b1) begin
                        state_next = ghe_pkg::ST_FINISH;
                    end else begin
                        pass_next  = pass_reg + 1'b1;
                        state_next = ghe_pkg::ST_R_RD;
                    end
                end else begin
                    if (y_last) begin
                        y_next = '0;
                        x_next = x_reg + 1'b1;
                    end else begin
                        y_next = y_reg + 1'b1;
                    end
                    state_next = ghe_pkg::ST_E_RD;
                end
            end
            default:
            begin
                state_next = ghe_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/ghe_checker.sv =====
`default_nettype none

module ghe_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic [1:0]         status,
    input logic signed [31:0] height_out,
    input logic signed [31:0] water_out,
    input logic signed [31:0] sediment_out
);

    // A stalled result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // Only a read returns cell values; write and run results carry zeros.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != 2'd2) |-> (height_out == 32'sd0) && (water_out == 32'sd0)
        && (sediment_out == 32'sd0))
        else $error("nonzero data on a write or run result");

    // No status code beyond the three defined ones.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status != 2'd3))
        else $error("undefined status code");

    // The block works on one item at a time, so a transfer is followed by a stall.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second item taken while busy");

endmodule

bind grid_hydraulic_erosion ghe_checker u_ghe_checker (.*);

`default_nettype wire

// ===== bench/tb_grid_hydraulic_erosion.sv =====
`timescale 1ns / 100ps

module tb_grid_hydraulic_erosion;

    import ghe_pkg::*;

    localparam longint LMAX = 64'sd2147483647;
    localparam longint LMIN = -64'sd2147483648;
    localparam longint ONE = 64'sd16777216;
    localparam int STRIDE = 256;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         operation = OP_WRITE;
    logic [7:0]         cell_x = 8'd0;
    logic [7:0]         cell_y = 8'd0;
    logic signed [31:0] height_in = 32'sd0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [1:0]         status;
    logic signed [31:0] height_out;
    logic signed [31:0] water_out;
    logic signed [31:0] sediment_out;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = REG_RAIN;
    logic [31:0]        cfg_data = 32'd0;

    grid_hydraulic_erosion u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .cell_x       (cell_x),
        .cell_y       (cell_y),
        .height_in    (height_in),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .height_out   (height_out),
        .water_out    (water_out),
        .sediment_out (sediment_out),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    typedef struct {
        logic [1:0]         st;
        logic signed [31:0] h;
        logic signed [31:0] w;
        logic signed [31:0] s;
    } cell_result_t;

    cell_result_t pending_results[$];

    logic [31:0] p_rain, p_sol, p_cap;
    logic [24:0] p_evap;
    logic [7:0]  p_passes;
    logic [1:0]  p_nbh;
    logic [8:0]  p_w, p_h;

    longint terrain[STRIDE*STRIDE];
    longint water[STRIDE*STRIDE];
    longint silt[STRIDE*STRIDE];
    longint dwat[STRIDE*STRIDE];
    longint dsilt[STRIDE*STRIDE];
    bit     written[STRIDE*STRIDE];

    int moore_dx[8] = '{-1, 0, 1, -1, 1, -1, 0, 1};
    int moore_dy[8] = '{-1, -1, -1, 0, 0, 1, 1, 1};
    int ortho_dx[4] = '{0, -1, 1, 0};
    int ortho_dy[4] = '{-1, 0, 0, 1};
    int diag_dx[4]  = '{-1, 1, -1, 1};
    int diag_dy[4]  = '{-1, -1, 1, 1};

    int send_gap_pct = 0;
    int stall_pct = 0;
    int hold_cycles = 0;
    int errors = 0;
    int n_items = 0;
    int n_runs = 0;
    int n_reads = 0;
    int n_checked = 0;

    always #5 clk = ~clk;

    initial
    begin
        #50_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles = hold_cycles - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cell_result_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            n_checked++;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: status %0d", status);
                errors++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (status !== e.st)
                begin
                    $error("status expected %0d actual %0d", e.st, status);
                    errors++;
                end
                if (height_out !== e.h)
                begin
                    $error("height_out expected %0d actual %0d", e.h, height_out);
                    errors++;
                end
                if (water_out !== e.w)
                begin
                    $error("water_out expected %0d actual %0d", e.w, water_out);
                    errors++;
                end
                if (sediment_out !== e.s)
                begin
                    $error("sediment_out expected %0d actual %0d", e.s, sediment_out);
                    errors++;
                end
            end
        end
    end

    function automatic longint clip(longint v);
        if (v > LMAX) return LMAX;
        if (v < LMIN) return LMIN;
        return v;
    endfunction

    function automatic longint scale_div(longint a, longint b, longint c);
        logic         neg;
        logic [63:0]  ma, mb, mc;
        logic [127:0] q;
        if (c == 0) return 0;
        neg = ((a < 0) != (b < 0)) != (c < 0);
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        mc = (c < 0) ? -c : c;
        q = ({64'd0, ma} * {64'd0, mb}) / {64'd0, mc};
        if (neg) return (q > 128'h8000_0000) ? LMIN : -longint'(q[63:0]);
        return (q > 128'h7FFF_FFFF) ? LMAX : longint'(q[63:0]);
    endfunction

    function automatic int side(logic [8:0] v);
        if (v < 2) return 2;
        if (v > STRIDE) return STRIDE;
        return int'(v);
    endfunction

    function automatic void flow_water(int gw, int gh);
        int     x, y, k, n, cnt, nx, ny, dx, dy, c, ni;
        int     nbi[8];
        longint drop[8];
        longint w, m, a, ai, dtot, asum, avg, mv, dw, dm;
        cnt = (p_nbh == NB_ORTHO || p_nbh == NB_DIAG) ? 4 : 8;
        for (x = 0; x < gw; x++)
            for (y = 0; y < gh; y++)
            begin
                dwat[x + y*STRIDE] = 0;
                dsilt[x + y*STRIDE] = 0;
            end
        for (x = 0; x < gw; x++)
            for (y = 0; y < gh; y++)
            begin
                c = x + y*STRIDE;
                w = water[c];
                m = silt[c];
                a = clip(terrain[c] + w);
                n = 0;
                dtot = 0;
                asum = 0;
                for (k = 0; k < cnt; k++)
                begin
                    if (p_nbh == NB_ORTHO)
                    begin
                        dx = ortho_dx[k];
                        dy = ortho_dy[k];
                    end
                    else if (p_nbh == NB_DIAG)
                    begin
                        dx = diag_dx[k];
                        dy = diag_dy[k];
                    end
                    else
                    begin
                        dx = moore_dx[k];
                        dy = moore_dy[k];
                    end
                    nx = x + dx;
                    ny = y + dy;
                    if (nx < 0 || ny < 0 || nx >= gw || ny >= gh) continue;
                    ni = nx + ny*STRIDE;
                    ai = clip(water[ni] + terrain[ni]);
                    if (ai < a)
                    begin
                        nbi[n] = ni;
                        drop[n] = clip(a - ai);
                        dtot = clip(dtot + drop[n]);
                        asum += ai;
                        n++;
                    end
                end
                if (n == 0) continue;
                avg = asum / n;
                mv = clip(a - avg);
                if (w < mv) mv = w;
                for (k = 0; k < n; k++)
                begin
                    dw = scale_div(mv, drop[k], dtot);
                    dm = (w == 0) ? 0 : scale_div(m, dw, w);
                    dwat[c] = clip(dwat[c] - dw);
                    dwat[nbi[k]] = clip(dwat[nbi[k]] + dw);
                    dsilt[c] = clip(dsilt[c] - dm);
                    dsilt[nbi[k]] = clip(dsilt[nbi[k]] + dm);
                end
            end
        for (x = 0; x < gw; x++)
            for (y = 0; y < gh; y++)
            begin
                c = x + y*STRIDE;
                water[c] = clip(water[c] + dwat[c]);
                silt[c] = clip(silt[c] + dsilt[c]);
            end
    endfunction

    function automatic void run_erosion();
        int     gw, gh, p, x, y, c;
        longint ev, keep, e, cap, ex;
        gw = side(p_w);
        gh = side(p_h);
        ev = (longint'(p_evap) > ONE) ? ONE : longint'(p_evap);
        keep = ONE - ev;
        for (p = 0; p < p_passes; p++)
        begin
            for (x = 0; x < gw; x++)
                for (y = 0; y < gh; y++)
                begin
                    c = x + y*STRIDE;
                    water[c] = clip(water[c] + longint'(p_rain));
                    e = scale_div(longint'(p_sol), water[c], ONE);
                    terrain[c] = clip(terrain[c] - e);
                    silt[c] = clip(silt[c] + e);
                end
            flow_water(gw, gh);
            for (x = 0; x < gw; x++)
                for (y = 0; y < gh; y++)
                begin
                    c = x + y*STRIDE;
                    water[c] = scale_div(water[c], keep, ONE);
                    cap = scale_div(longint'(p_cap), water[c], ONE);
                    ex = clip(silt[c] - cap);
                    if (ex < 0) ex = 0;
                    terrain[c] = clip(terrain[c] + ex);
                    silt[c] = clip(silt[c] - ex);
                end
        end
    endfunction

    function automatic int cell_index(logic [7:0] x, logic [7:0] y);
        int cx, cy;
        cx = (x > side(p_w) - 1) ? side(p_w) - 1 : int'(x);
        cy = (y > side(p_h) - 1) ? side(p_h) - 1 : int'(y);
        return cx + cy*STRIDE;
    endfunction

    function automatic void predict_item(logic [1:0] op, logic [7:0] x, logic [7:0] y,
                                         logic signed [31:0] h);
        cell_result_t r;
        int           c;
        r = '{STATUS_WRITE, 32'sd0, 32'sd0, 32'sd0};
        c = cell_index(x, y);
        if (op == OP_WRITE)
        begin
            terrain[c] = longint'(h);
            written[c] = 1'b1;
        end
        else if (op == OP_RUN)
        begin
            run_erosion();
            r.st = STATUS_RUN;
            n_runs++;
        end
        else
        begin
            r.st = STATUS_READ;
            r.h = terrain[c][31:0];
            r.w = water[c][31:0];
            r.s = silt[c][31:0];
            n_reads++;
        end
        pending_results.push_back(r);
    endfunction

    function automatic logic signed [31:0] rand_height();
        if ($urandom_range(0, 9) == 0) return $urandom;
        return $signed($urandom_range(0, 32'h1000_0000)) - 32'sh0800_0000;
    endfunction

    task automatic transfer_item(logic [1:0] op, logic [7:0] x, logic [7:0] y,
                                 logic signed [31:0] h);
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        cell_x <= x;
        cell_y <= y;
        height_in <= h;
        do @(posedge clk); while (in_stall);
        n_items++;
        predict_item(op, x, y, h);
    endtask

    // Cells whose height was never loaded are written first, so that neither a read
    // nor a run ever sees an undefined height.
    task automatic send(logic [1:0] op, logic [7:0] x, logic [7:0] y,
                        logic signed [31:0] h);
        int cx, cy, c;
        if (op == OP_RUN)
        begin
            for (cx = 0; cx < side(p_w); cx++)
                for (cy = 0; cy < side(p_h); cy++)
                    if (!written[cx + cy*STRIDE])
                        transfer_item(OP_WRITE, cx, cy, rand_height());
        end
        else if (op != OP_WRITE)
        begin
            c = cell_index(x, y);
            if (!written[c])
                transfer_item(OP_WRITE, c % STRIDE, c / STRIDE, rand_height());
        end
        transfer_item(op, x, y, h);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_RAIN:   p_rain = data;
            REG_SOL:    p_sol = data;
            REG_EVAP:   p_evap = data[24:0];
            REG_CAP:    p_cap = data;
            REG_PASSES: p_passes = data[7:0];
            REG_NBH:    p_nbh = data[1:0];
            REG_WIDTH:  p_w = data[8:0];
            default:    p_h = data[8:0];
        endcase
        @(posedge clk);
    endtask

    task automatic test_memory_ops();
        send(OP_WRITE, 8'd0, 8'd0, 32'sh8000_0000);
        send(OP_WRITE, 8'd255, 8'd255, 32'sh7FFF_FFFF);
        send(OP_READ, 8'd0, 8'd0, 32'sd0);
        send(2'd3, 8'd255, 8'd255, 32'sd0);
    endtask

    task automatic test_grid_clamp();
        drain();
        write_reg(REG_WIDTH, 32'd511);
        write_reg(REG_HEIGHT, 32'd300);
        send(OP_READ, 8'd255, 8'd255, 32'sd0);
        drain();
        write_reg(REG_WIDTH, 32'd0);
        write_reg(REG_HEIGHT, 32'd1);
        send(OP_WRITE, 8'd200, 8'd7, 32'sh0200_0000);
        send(OP_READ, 8'd1, 8'd1, 32'sd0);
    endtask

    task automatic test_special_runs();
        drain();
        write_reg(REG_RAIN, 32'd0);
        write_reg(REG_PASSES, 32'd1);
        send(OP_RUN, 8'd0, 8'd0, 32'sd0);
        drain();
        write_reg(REG_PASSES, 32'd0);
        send(OP_RUN, 8'd0, 8'd0, 32'sd0);
        send(OP_READ, 8'd0, 8'd1, 32'sd0);
        drain();
        write_reg(REG_RAIN, 32'd25166);
        write_reg(REG_EVAP, 32'h01FF_FFFF);
        write_reg(REG_NBH, 32'd3);
        write_reg(REG_PASSES, 32'd1);
        send(OP_RUN, 8'd0, 8'd0, 32'sd0);
        send(OP_READ, 8'd1, 8'd0, 32'sd0);
        drain();
        write_reg(REG_RAIN, 32'hFFFF_FFFF);
        write_reg(REG_SOL, 32'hFFFF_FFFF);
        write_reg(REG_CAP, 32'd0);
        send(OP_RUN, 8'd0, 8'd0, 32'sd0);
        send(OP_READ, 8'd1, 8'd1, 32'sd0);
        drain();
        write_reg(REG_RAIN, 32'd25166);
        write_reg(REG_SOL, 32'd419430);
        write_reg(REG_EVAP, 32'd0);
        write_reg(REG_CAP, 32'hFFFF_FFFF);
        write_reg(REG_NBH, NB_DIAG);
        send(OP_WRITE, 8'd0, 8'd0, 32'sh0400_0000);
        send(OP_RUN, 8'd0, 8'd0, 32'sd0);
        send(OP_READ, 8'd0, 8'd0, 32'sd0);
        drain();
        write_reg(REG_NBH, NB_ORTHO);
        write_reg(REG_EVAP, 32'h0100_0000);
        write_reg(REG_PASSES, 32'd255);
        send(OP_RUN, 8'd0, 8'd0, 32'sd0);
        send(OP_READ, 8'd1, 8'd0, 32'sd0);
    endtask

    task automatic test_backpressure();
        int i;
        drain();
        write_reg(REG_WIDTH, 32'd4);
        write_reg(REG_HEIGHT, 32'd4);
        write_reg(REG_PASSES, 32'd1);
        write_reg(REG_NBH, 32'd0);
        send_gap_pct = 0;
        stall_pct = 0;
        hold_cycles = 300;
        for (i = 0; i < 30; i++)
            send(OP_READ, $urandom, $urandom, 32'sd0);
        drain();
    endtask

    task automatic random_setup();
        drain();
        write_reg(REG_RAIN, $urandom_range(0, 32'h0200_0000));
        write_reg(REG_SOL, $urandom_range(0, 32'h0100_0000));
        write_reg(REG_EVAP, $urandom_range(0, 32'h0120_0000));
        write_reg(REG_CAP, $urandom_range(0, 32'h1000_0000));
        write_reg(REG_PASSES, $urandom_range(1, 2));
        write_reg(REG_NBH, $urandom_range(0, 3));
        write_reg(REG_WIDTH, $urandom_range(2, 4));
        write_reg(REG_HEIGHT, $urandom_range(2, 3));
    endtask

    task automatic random_item();
        logic [1:0] op;
        logic [7:0] x, y;
        int         pick;
        pick = $urandom_range(0, 99);
        if (pick < 2) op = OP_RUN;
        else if (pick < 45) op = OP_WRITE;
        else if (pick < 90) op = OP_READ;
        else op = 2'd3;
        if ($urandom_range(0, 3) == 0)
        begin
            x = $urandom;
            y = $urandom;
        end
        else
        begin
            x = $urandom_range(0, side(p_w) - 1);
            y = $urandom_range(0, side(p_h) - 1);
        end
        send(op, x, y, rand_height());
    endtask

    task automatic test_random();
        int ph, i;
        int gaps[4] = '{0, 54, 0, 13};
        int stalls[4] = '{0, 0, 54, 13};
        for (ph = 0; ph < 4; ph++)
        begin
            for (i = 0; i < 400; i++)
            begin
                if (i % 100 == 0)
                begin
                    random_setup();
                    send_gap_pct = gaps[ph];
                    stall_pct = stalls[ph];
                end
                random_item();
            end
        end
    endtask

    initial
    begin
        p_rain = 32'd25166;
        p_sol = 32'd419430;
        p_evap = 25'd2516582;
        p_cap = 32'd167772160;
        p_passes = 8'd50;
        p_nbh = 2'd0;
        p_w = 9'd256;
        p_h = 9'd256;
        for (int i = 0; i < STRIDE*STRIDE; i++)
        begin
            terrain[i] = 0;
            water[i] = 0;
            silt[i] = 0;
            written[i] = 1'b0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_memory_ops();
        test_grid_clamp();
        test_special_runs();
        test_backpressure();
        test_random();
        drain();
        repeat (50) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_results.size());
            errors++;
        end
        $display("Sent %0d items (%0d erosion runs, %0d cell reads), checked %0d results,",
                 n_items, n_runs, n_reads, n_checked);
        $display("under four idling mixes, one long output hold and config extremes.");
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
